// File: rtl/mac_face_pressure_projection_macros.svh
// Assertion macros for the face pressure projection block.
`ifndef MAC_FACE_PRESSURE_PROJECTION_MACROS_SVH
`define MAC_FACE_PRESSURE_PROJECTION_MACROS_SVH
// implication checked in the next cycle, reset cycles included
`define MFPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mfpp assertion failed");
// implication checked in the next cycle, masked while in reset
`define MFPP_ASSERT_RUN(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mfpp assertion failed");
`endif

// File: rtl/mfpp_pkg.sv
// Shared types for the face pressure projection block.
package mfpp_pkg;
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_MODE     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STEP     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FALLBACK = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_FLOOR    = 2'd3;

    typedef struct packed {
        logic        density_mode;
        logic [31:0] step_over_spacing;
        logic [31:0] fallback_density;
        logic [31:0] density_floor;
    } t_cfg;

    // classified face, queued between front and back
    typedef struct packed {
        logic signed [31:0] vel;
        logic               upd;
        logic               dens;
        logic               neg;
        logic [32:0]        dabs;
        logic [31:0]        rho;
    } t_cls;
endpackage

// File: rtl/mfpp_in_if.sv
// Input face channel.
interface mfpp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] velocity_in;
    logic signed [31:0] pressure_here;
    logic signed [31:0] pressure_neighbor;
    logic               solid_here;
    logic               solid_neighbor;
    logic               fluid_here;
    logic               fluid_neighbor;
    logic               face_open;
    logic [31:0]        density_here;
    logic [31:0]        density_neighbor;
    modport source (output valid, velocity_in, pressure_here, pressure_neighbor, solid_here,
                    solid_neighbor, fluid_here, fluid_neighbor, face_open, density_here,
                    density_neighbor, input ready);
    modport sink (input valid, velocity_in, pressure_here, pressure_neighbor, solid_here,
                  solid_neighbor, fluid_here, fluid_neighbor, face_open, density_here,
                  density_neighbor, output ready);
endinterface

// File: rtl/mfpp_out_if.sv
// Result channel.
interface mfpp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] velocity_out;
    logic               face_updated;
    modport source (output valid, velocity_out, face_updated, input ready);
    modport sink (input valid, velocity_out, face_updated, output ready);
endinterface

// File: rtl/mfpp_front.sv
// Front end: accepts faces and classifies them for the arithmetic back end.
module mfpp_front (
    mfpp_in_if.sink        i_in,
    input  mfpp_pkg::t_cfg i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output mfpp_pkg::t_cls o_cls
);
    import mfpp_pkg::*;

    logic signed [31:0] ph_s;
    logic signed [31:0] pn_s;
    logic signed [32:0] diff;
    logic [32:0]        dsum;
    logic [31:0]        mean;
    logic [31:0]        rho0;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        ph_s = i_in.solid_here ? i_in.pressure_neighbor : i_in.pressure_here;
        pn_s = i_in.solid_neighbor ? ph_s : i_in.pressure_neighbor;
        diff = 33'(ph_s) - 33'(pn_s);
        dsum = {1'b0, i_in.density_here} + {1'b0, i_in.density_neighbor};
        mean = dsum[32:1];
        rho0 = (mean < i_cfg.density_floor) ? i_cfg.fallback_density : mean;
        o_cls.vel  = i_in.velocity_in;
        o_cls.dens = i_cfg.density_mode;
        o_cls.upd  = i_cfg.density_mode ? i_in.face_open
                                        : (i_in.fluid_here || i_in.fluid_neighbor);
        o_cls.neg  = diff[32];
        o_cls.dabs = diff[32] ? 33'(-diff) : 33'(diff);
        o_cls.rho  = (rho0 == 32'd0) ? 32'd1 : rho0;
    end
endmodule

// File: rtl/mfpp_queue.sv
// Short queue decoupling the front end from the back end.
module mfpp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfpp_pkg::t_cls i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output mfpp_pkg::t_cls o_data
);
    import mfpp_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = i_push ? ((r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_pop ? ((r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CntW'(i_push) - CntW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// File: rtl/mfpp_back.sv
// Back end: multiply, one-bit-per-stage divide in density mode, round and saturate.
module mfpp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mfpp_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  mfpp_pkg::t_cls i_cls,
    output logic           o_pop,
    mfpp_out_if.source     o_out
);
    import mfpp_pkg::*;

    localparam int unsigned QBits = 48;

    typedef struct packed {
        logic signed [31:0] vel;
        logic               upd;
        logic               dens;
        logic               neg;
        logic               ovf;
        logic [31:0]        r;
        logic [31:0]        rem;
        logic [QBits-1:0]   nlo;
        logic [QBits:0]     q;
    } t_stg;

    typedef struct packed {
        logic signed [31:0] vel;
        logic               upd;
        logic               dens;
        logic               neg;
        logic               dhi;
        logic [31:0]        r;
        logic [63:0]        pm;
    } t_mul;

    logic             en;
    logic             r_av;
    t_mul             r_a;
    t_mul             n_a;
    logic             r_dv [QBits+1];
    t_stg             r_d  [QBits+1];
    t_stg             n_d  [QBits+1];
    logic             r_ov;
    logic signed [31:0] r_vel;
    logic             r_upd;
    logic [63:0]      p;
    logic [63:0]      pr;
    logic [49:0]      mag;
    logic signed [51:0] res;
    logic signed [31:0] n_vel;

    assign en          = !r_ov || o_out.ready;
    assign o_pop       = en;
    assign o_out.valid = r_ov;
    assign o_out.velocity_out = r_vel;
    assign o_out.face_updated = r_upd;

    always_comb begin
        n_a.vel  = i_cls.vel;
        n_a.upd  = i_cls.upd;
        n_a.dens = i_cls.dens;
        n_a.neg  = i_cls.neg;
        n_a.dhi  = i_cls.dabs[32];
        n_a.r    = i_cls.rho;
        n_a.pm   = 64'(i_cfg.step_over_spacing) * 64'(i_cls.dabs[31:0]);
    end

    always_comb begin
        p  = r_a.pm + (r_a.dhi ? {i_cfg.step_over_spacing, 32'd0} : 64'd0);
        pr = p + 64'h8000;
        n_d[0].vel  = r_a.vel;
        n_d[0].upd  = r_a.upd;
        n_d[0].dens = r_a.dens;
        n_d[0].neg  = r_a.neg;
        n_d[0].r    = r_a.r;
        n_d[0].ovf  = ({8'd0, p[63:40]} >= r_a.r);
        n_d[0].rem  = {8'd0, p[63:40]};
        n_d[0].nlo  = {p[39:0], 8'd0};
        n_d[0].q    = r_a.dens ? '0 : {1'b0, pr[63:16]};
    end

    for (genvar k = 0; k < QBits; k++) begin : g_div
        logic [32:0] rs;
        logic        ge;
        always_comb begin
            rs = {r_d[k].rem, r_d[k].nlo[QBits-1]};
            ge = (rs >= {1'b0, r_d[k].r});
            n_d[k+1] = r_d[k];
            if (r_d[k].dens && !r_d[k].ovf) begin
                n_d[k+1].rem = ge ? 32'(rs - {1'b0, r_d[k].r}) : rs[31:0];
                n_d[k+1].nlo = {r_d[k].nlo[QBits-2:0], 1'b0};
                n_d[k+1].q   = {r_d[k].q[QBits-1:0], ge};
            end
        end
    end

    always_comb begin
        priority if (!r_d[QBits].dens) begin
            mag = 50'(r_d[QBits].q);
        end else if (r_d[QBits].ovf) begin
            mag = 50'(1) << QBits;
        end else begin
            mag = 50'(r_d[QBits].q)
                + 50'(({r_d[QBits].rem, 1'b0} >= {1'b0, r_d[QBits].r}));
        end
        res = r_d[QBits].neg ? 52'(r_d[QBits].vel) + 52'(mag)
                             : 52'(r_d[QBits].vel) - 52'(mag);
        priority if (!r_d[QBits].upd) begin
            n_vel = r_d[QBits].vel;
        end else if (res > 52'sd2147483647) begin
            n_vel = 32'sh7fffffff;
        end else if (res < -52'sd2147483648) begin
            n_vel = 32'sh80000000;
        end else begin
            n_vel = res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i <= QBits; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_av    <= i_valid;
            r_dv[0] <= r_av;
            for (int i = 0; i < QBits; i++) begin
                r_dv[i+1] <= r_dv[i];
            end
            r_ov <= r_dv[QBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a   <= n_a;
            for (int i = 0; i <= QBits; i++) begin
                r_d[i] <= n_d[i];
            end
            r_vel <= n_vel;
            r_upd <= r_d[QBits].upd;
        end
    end
endmodule

// File: rtl/mac_face_pressure_projection.sv
// Throughput: one face per cycle; the 48-stage quotient pipeline and a single
// 32x32 multiplier each take a new face every cycle, stalled only by the output.
// A queue of QDEPTH entries separates input acceptance from the arithmetic pipeline.
// Reset (synchronous, active low) empties queue and pipeline and loads the
// register reset values: density mode, step 5243, fallback 1.0, floor 17.
module mac_face_pressure_projection #(
    parameter int unsigned QDEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mfpp_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    mfpp_in_if.sink                      i_in,
    mfpp_out_if.source                   o_out
);
    import mfpp_pkg::*;

    t_cfg r_cfg;
    t_cls f_cls;
    t_cls q_cls;
    logic f_push;
    logic q_full;
    logic q_valid;
    logic b_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.density_mode      <= 1'b1;
            r_cfg.step_over_spacing <= 32'd5243;
            r_cfg.fallback_density  <= 32'd16777216;
            r_cfg.density_floor     <= 32'd17;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:     r_cfg.density_mode      <= i_cfg_data[0];
                CFG_STEP:     r_cfg.step_over_spacing <= i_cfg_data;
                CFG_FALLBACK: r_cfg.fallback_density  <= i_cfg_data;
                CFG_FLOOR:    r_cfg.density_floor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfpp_front u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (q_full),
        .o_push (f_push),
        .o_cls  (f_cls)
    );

    mfpp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cls),
        .i_pop   (b_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    mfpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_pop   (b_pop),
        .o_out   (o_out)
    );
endmodule

// File: rtl/mfpp_checker.sv
// Port-level assertions for the face pressure projection block, with bind.
`include "mac_face_pressure_projection_macros.svh"
module mfpp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_out_vel,
    input logic               i_out_upd
);
    `MFPP_ASSERT_NEXT(a_rst_no_out, !i_rst_n, !i_out_valid)
    `MFPP_ASSERT_NEXT(a_rst_ready, !i_rst_n, i_in_ready)
    `MFPP_ASSERT_NEXT(a_first_out_late, !i_rst_n, !i_out_valid [*40])
    `MFPP_ASSERT_RUN(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_vel) && $stable(i_out_upd))
endmodule

bind mac_face_pressure_projection mfpp_checker u_mfpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_vel   (o_out.velocity_out),
    .i_out_upd   (o_out.face_updated)
);
